[design/bitmap_first_free_allocator_macros.svh]
// assertion macros for the bitmap first free allocator
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BFFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BFFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bffa_pkg.sv]
`timescale 1ns / 1ps

package bffa_pkg;

    localparam int NUM_W     = 14;
    localparam int NUM_MAX   = (2 ** NUM_W) - 1;
    localparam int STS_W     = 2;
    localparam int WORD_BITS = 128;
    localparam int BIT_W     = $clog2(WORD_BITS);

    localparam logic [NUM_W-1:0] TOTAL_RESET = 14'd8192;

    typedef enum logic [STS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_ALREADY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_FREE_CHK,
        S_SCAN,
        S_DELIVER
    } state_t;

    typedef struct packed {
        logic    accept;
        logic    clear_step;
        logic    alloc_first_rd;
        logic    free_rd;
        logic    scan_next_rd;
        logic    alloc_commit;
        logic    free_commit;
        logic    res_load;
        status_t res_status;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic req_free;
        logic eff_zero;
        logic num_bad;
        logic bit_set;
        logic found;
        logic last_word;
        logic clear_last;
    } sts_t;

endpackage

[design/bffa_ctrl.sv]
`timescale 1ns / 1ps

module bffa_ctrl
    import bffa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic out_stall,
    input  sts_t sts,
    output logic in_stall,
    output logic out_valid,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = ST_OK;
        state_next     = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (!sts.req_free)
                begin
                    if (sts.eff_zero)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_FULL;
                        state_next     = S_DELIVER;
                    end
                    else
                    begin
                        cmd.alloc_first_rd = 1'b1;
                        state_next         = S_SCAN;
                    end
                end
                else if (sts.num_bad)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_RANGE;
                    state_next     = S_DELIVER;
                end
                else
                begin
                    cmd.free_rd = 1'b1;
                    state_next  = S_FREE_CHK;
                end
            end
            S_FREE_CHK:
            begin
                cmd.res_load = 1'b1;
                if (sts.bit_set)
                begin
                    cmd.free_commit = 1'b1;
                    cmd.res_status  = ST_OK;
                end
                else
                begin
                    cmd.res_status = ST_ALREADY;
                end
                state_next = S_DELIVER;
            end
            S_SCAN:
            begin
                if (sts.found)
                begin
                    cmd.alloc_commit = 1'b1;
                    cmd.res_load     = 1'b1;
                    cmd.res_status   = ST_OK;
                    state_next       = S_DELIVER;
                end
                else if (sts.last_word)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_FULL;
                    state_next     = S_DELIVER;
                end
                else
                begin
                    cmd.scan_next_rd = 1'b1;
                end
            end
            S_DELIVER:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[design/bffa_datapath.sv]
`timescale 1ns / 1ps

module bffa_datapath
    import bffa_pkg::*;
#(
    parameter int ENTRIES = 8192
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [NUM_W-1:0] cfg_data,
    input  logic             req_type,
    input  logic [NUM_W-1:0] entry_number,
    input  cmd_t             cmd,
    output sts_t             sts,
    output logic [NUM_W-1:0] allocated_number,
    output logic [STS_W-1:0] status,
    output logic [NUM_W-1:0] free_count
);

    localparam int WORDS  = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);
    localparam logic [NUM_W-1:0]  ENT_CAP   =
        (ENTRIES >= NUM_MAX) ? NUM_W'(NUM_MAX) : NUM_W'(ENTRIES);

    // bits of the word index that carry bit b of a position
    function automatic logic [WORD_BITS-1:0] pos_mask(input int b);
        logic [WORD_BITS-1:0] m;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            m[j] = ((j >> b) & 1) != 0;
        end
        return m;
    endfunction

    logic [WORD_BITS-1:0] mem [WORDS];

    logic [NUM_W-1:0]     total_reg;
    logic [NUM_W-1:0]     used_reg;
    logic [ADDR_W-1:0]    clear_ptr_reg;
    logic                 req_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [ADDR_W-1:0]    rd_ptr_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic [NUM_W-1:0]     res_num_reg;
    status_t              res_status_reg;
    logic [NUM_W-1:0]     allocated_number_reg;
    status_t              status_reg;
    logic [NUM_W-1:0]     free_count_reg;

    logic [NUM_W-1:0]     eff;
    logic [NUM_W-1:0]     eff_m1;
    logic [ADDR_W-1:0]    last_word;
    logic [BIT_W-1:0]     last_bit;
    logic [NUM_W-1:0]     idx;
    logic [ADDR_W-1:0]    free_addr;
    logic [BIT_W-1:0]     free_pos;
    logic                 at_last;
    logic [WORD_BITS-1:0] valid_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] lowest;
    logic [BIT_W-1:0]     pos;
    logic [NUM_W-1:0]     found_num;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    assign eff       = (total_reg > ENT_CAP) ? ENT_CAP : total_reg;
    assign eff_m1    = eff - NUM_W'(1);
    assign last_word = ADDR_W'(eff_m1 >> BIT_W);
    assign last_bit  = eff_m1[BIT_W-1:0];
    assign idx       = num_reg - NUM_W'(1);
    assign free_addr = ADDR_W'(idx >> BIT_W);
    assign free_pos  = idx[BIT_W-1:0];
    assign at_last   = (rd_ptr_reg == last_word);

    // bit positions at or above the effective total count as taken in the last word
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            valid_mask[j] = !at_last || (BIT_W'(j) <= last_bit);
        end
    end

    assign free_bits = ~rdata_reg & valid_mask;
    assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));

    always_comb
    begin
        for (int b = 0; b < BIT_W; b++)
        begin
            pos[b] = |(lowest & pos_mask(b));
        end
    end

    assign found_num = NUM_W'({rd_ptr_reg, pos}) + NUM_W'(1);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = rd_ptr_reg;
        if (cmd.alloc_first_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end
        else if (cmd.free_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = free_addr;
        end
        else if (cmd.scan_next_rd)
        begin
            rd_en   = 1'b1;
            rd_addr = rd_ptr_reg + ADDR_W'(1);
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_ptr_reg;
        wr_data = rdata_reg;
        if (cmd.clear_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clear_ptr_reg;
            wr_data = '0;
        end
        else if (cmd.alloc_commit)
        begin
            wr_en   = 1'b1;
            wr_data = rdata_reg | lowest;
        end
        else if (cmd.free_commit)
        begin
            wr_en   = 1'b1;
            wr_data = rdata_reg & ~(WORD_BITS'(1) << free_pos);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= TOTAL_RESET;
            used_reg      <= '0;
            clear_ptr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                total_reg <= cfg_data;
            end
            if (cmd.alloc_commit)
            begin
                used_reg <= used_reg + NUM_W'(1);
            end
            else if (cmd.free_commit && (used_reg != '0))
            begin
                used_reg <= used_reg - NUM_W'(1);
            end
            if (cmd.clear_step)
            begin
                clear_ptr_reg <= clear_ptr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req_type;
            num_reg <= entry_number;
        end
        if (rd_en)
        begin
            rd_ptr_reg <= rd_addr;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_num_reg    <= cmd.alloc_commit ? found_num : '0;
        end
        if (cmd.out_load)
        begin
            allocated_number_reg <= res_num_reg;
            status_reg           <= res_status_reg;
            free_count_reg       <= (eff > used_reg) ? (eff - used_reg) : '0;
        end
    end

    assign sts.req_free   = req_reg;
    assign sts.eff_zero   = (eff == '0);
    assign sts.num_bad    = (num_reg == '0) || (num_reg > eff);
    assign sts.bit_set    = rdata_reg[free_pos];
    assign sts.found      = |free_bits;
    assign sts.last_word  = at_last;
    assign sts.clear_last = (clear_ptr_reg == LAST_ADDR);

    assign allocated_number = allocated_number_reg;
    assign status           = status_reg;
    assign free_count       = free_count_reg;

endmodule

[design/bitmap_first_free_allocator.sv]
// free request: START, FREE_CHK reads and tests the bit, DELIVER; next item taken back in IDLE
// allocate: START reads word 0, SCAN tests words (128 entries each) up to a hit or the last word;
//   a full scan reads ceil(min(total, ENTRIES) / 128) words, one per cycle (64 for 8192)
// usage memory read port sets the allocate scan rate; out-of-range and zero-total skip to DELIVER
// reset: clears the count and sets the total to 8192, then a clearing pass
//   zeroes the bitmap word by word with in_stall high; config writes still taken
`timescale 1ns / 1ps
`include "bitmap_first_free_allocator_macros.svh"

module bitmap_first_free_allocator
    import bffa_pkg::*;
#(
    parameter int ENTRIES = 8192
)
(
    input  logic             clk,
    input  logic             rst_n,

    // config write channel, total entry count
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [NUM_W-1:0] cfg_data,

    // request channel
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             req_type,
    input  logic [NUM_W-1:0] entry_number,

    // result channel
    output logic             out_valid,
    input  logic             out_stall,
    output logic [NUM_W-1:0] allocated_number,
    output logic [STS_W-1:0] status,
    output logic [NUM_W-1:0] free_count
);

    cmd_t cmd;
    sts_t sts;
    logic cfg_we;

    // the register is always writable, also during the clearing pass
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // controller: clearing pass, request sequencing, result handoff
    bffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // datapath: usage memory, first-free search, counts, result registers
    bffa_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .req_type         (req_type),
        .entry_number     (entry_number),
        .cmd              (cmd),
        .sts              (sts),
        .allocated_number (allocated_number),
        .status           (status),
        .free_count       (free_count)
    );

    // one transaction in flight: an accepted request blocks the next cycle
    `BFFA_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "request taken twice")

    // a nonzero number only comes with an ok status
    `BFFA_ASSERT_NOW(a_num_means_ok, out_valid && (allocated_number != '0), status == ST_OK,
        "number returned without ok status")

    // full means every entry below the total is counted as used
    `BFFA_ASSERT_NOW(a_full_no_free, out_valid && (status == ST_FULL), free_count == '0,
        "full reported with free entries left")

    // no request is taken while the bitmap is being cleared
    `BFFA_ASSERT_NOW(a_clear_blocks, cmd.clear_step, in_stall, "request open during clear")

endmodule

[tb/bffa_result_checker.sv]
`timescale 1ns / 1ps

package bffa_tb_pkg;

    // request kinds on req_type
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

endpackage

module bffa_result_checker
    import bffa_pkg::*;
    import bffa_tb_pkg::*;
#(
    parameter int ENTRIES = 8192
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [NUM_W-1:0] cfg_data,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic             req_type,
    input  logic [NUM_W-1:0] entry_number,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic [NUM_W-1:0] allocated_number,
    input  logic [STS_W-1:0] status,
    input  logic [NUM_W-1:0] free_count,
    output int               fail_count,
    output int               outstanding,
    output int               checked,
    output int               n_granted,
    output int               n_released,
    output int               n_full,
    output int               n_range,
    output int               n_already
);

    typedef struct packed {
        logic [NUM_W-1:0] number;
        status_t          sts;
        logic [NUM_W-1:0] left;
    } alloc_answer_t;

    bit            usage_map [ENTRIES];
    int unsigned   used_total;
    int unsigned   total_reg;
    int            misses;
    alloc_answer_t pending_answers [$];
    alloc_answer_t want;

    // first-fit allocate or release, updates the shadow bitmap
    function automatic alloc_answer_t answer_request(input logic kind,
                                                     input logic [NUM_W-1:0] num);
        alloc_answer_t a;
        int unsigned   lim;
        lim      = (total_reg < ENTRIES) ? total_reg : ENTRIES;
        a.number = '0;
        a.sts    = ST_OK;
        if (kind == REQ_ALLOC)
        begin
            a.sts = ST_FULL;
            for (int i = 0; i < lim; i++)
            begin
                if (!usage_map[i])
                begin
                    usage_map[i] = 1'b1;
                    used_total++;
                    a.number = NUM_W'(i + 1);
                    a.sts    = ST_OK;
                    break;
                end
            end
        end
        else if (num == 0 || num > lim)
            a.sts = ST_RANGE;
        else if (!usage_map[num - 1])
            a.sts = ST_ALREADY;
        else
        begin
            usage_map[num - 1] = 1'b0;
            if (used_total > 0)
                used_total--;
        end
        a.left = (lim > used_total) ? NUM_W'(lim - used_total) : '0;
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (usage_map[i])
                usage_map[i] = 1'b0;
            used_total = 0;
            total_reg  = TOTAL_RESET;
            misses     = 0;
            pending_answers.delete();
            fail_count  <= 0;
            outstanding <= 0;
            checked     <= 0;
            n_granted   <= 0;
            n_released  <= 0;
            n_full      <= 0;
            n_range     <= 0;
            n_already   <= 0;
        end
        else
        begin
            // results first: one accepted now belongs to an earlier request
            if (out_valid && !out_stall)
            begin
                checked <= checked + 1;
                if (pending_answers.size() == 0)
                begin
                    misses++;
                    if (misses <= 10)
                        $display("[%0t] unexpected result: number %0d status %0d free %0d",
                                 $realtime, allocated_number, status, free_count);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (allocated_number !== want.number || status !== want.sts
                        || free_count !== want.left)
                    begin
                        misses++;
                        if (misses <= 10)
                        begin
                            $display("[%0t] mismatch: expected number %0d status %0d free %0d",
                                     $realtime, want.number, want.sts, want.left);
                            $display("    got number %0d status %0d free %0d",
                                     allocated_number, status, free_count);
                        end
                    end
                    case (want.sts)
                        ST_OK:
                            if (want.number != 0)
                                n_granted <= n_granted + 1;
                            else
                                n_released <= n_released + 1;
                        ST_FULL:    n_full <= n_full + 1;
                        ST_RANGE:   n_range <= n_range + 1;
                        ST_ALREADY: n_already <= n_already + 1;
                        default:    ;
                    endcase
                end
            end
            if (in_valid && !in_stall)
                pending_answers.push_back(answer_request(req_type, entry_number));
            if (cfg_valid && cfg_ready)
                total_reg = cfg_data;
            fail_count  <= misses;
            outstanding <= pending_answers.size();
        end
    end

endmodule

[tb/bitmap_first_free_allocator_tb.sv]
`timescale 1ns / 1ps

module bitmap_first_free_allocator_tb
    import bffa_pkg::*;
    import bffa_tb_pkg::*;
();

    localparam int  ENTRIES     = 8192;
    localparam int  CLK_PERIOD  = 10;
    // long receiver hold-off so the block backs up and stalls its input
    localparam int  HOLD_CYCLES = 300;
    localparam int  PHASES      = 12;
    localparam int  PHASE_ITEMS = 130;
    // worst case is roughly 1600 items, each at its slowest, taken several times over
    localparam time LIMIT_NS    = 10_000_000;

    // every block input starts at a known value
    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             cfg_valid    = 1'b0;
    logic [NUM_W-1:0] cfg_data     = '0;
    logic             in_valid     = 1'b0;
    logic             req_type     = 1'b0;
    logic [NUM_W-1:0] entry_number = '0;
    logic             out_stall    = 1'b0;

    logic             cfg_ready;
    logic             in_stall;
    logic             out_valid;
    logic [NUM_W-1:0] allocated_number;
    logic [STS_W-1:0] status;
    logic [NUM_W-1:0] free_count;

    // checker outputs
    int fail_count;
    int outstanding;
    int checked;
    int n_granted;
    int n_released;
    int n_full;
    int n_range;
    int n_already;

    // stimulus bookkeeping
    int requests_sent = 0;
    int cfg_writes    = 0;
    // rough count of low entries in use, steers frees toward set bits
    int live_hint     = 0;
    // per-phase switches for stretches without any idling
    bit snd_steady    = 1'b0;
    bit rcv_steady    = 1'b0;
    // bumped by the main sequence, served by the result sink
    int hold_requests = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    bitmap_first_free_allocator #(
        .ENTRIES(ENTRIES)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .entry_number     (entry_number),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .allocated_number (allocated_number),
        .status           (status),
        .free_count       (free_count)
    );

    bffa_result_checker #(
        .ENTRIES(ENTRIES)
    ) result_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .entry_number     (entry_number),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .allocated_number (allocated_number),
        .status           (status),
        .free_count       (free_count),
        .fail_count       (fail_count),
        .outstanding      (outstanding),
        .checked          (checked),
        .n_granted        (n_granted),
        .n_released       (n_released),
        .n_full           (n_full),
        .n_range          (n_range),
        .n_already        (n_already)
    );

    // one request transaction; called at a rising edge, returns at the accepting edge
    // valid stays high after the accept so back-to-back requests need no extra step
    task automatic post_request(input logic kind, input logic [NUM_W-1:0] num);
        int gap;
        gap = snd_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        entry_number <= num;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
    endtask

    // drop valid, then wait until every request has been answered
    // the outstanding count read at an edge reflects the edge before it
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // write the entry total; only done with nothing in flight
    task automatic write_total(input logic [NUM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // random mix of allocates and frees against one total setting
    // most frees aim at low numbers that first-fit has likely handed out,
    // the rest are zero, at or just past the total, or anything at all
    task automatic run_phase(input int unsigned total, input int count, input int alloc_pct);
        int eff;
        int pick;
        int num;
        eff = (total < ENTRIES) ? total : ENTRIES;
        if (live_hint > eff)
            live_hint = eff;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < alloc_pct)
            begin
                // entry_number is ignored on allocate, so fill it with noise
                post_request(REQ_ALLOC, NUM_W'($urandom_range(0, NUM_MAX)));
                if (live_hint < eff)
                    live_hint++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    num = $urandom_range(1, live_hint + 2);
                else if (pick < 85)
                    num = 0;
                else if (pick < 92)
                    num = eff + $urandom_range(0, 3);
                else
                    num = $urandom_range(0, NUM_MAX);
                post_request(REQ_FREE, NUM_W'(num));
                if (pick < 80 && live_hint > 0)
                    live_hint--;
            end
        end
    endtask

    // result sink: random stall before each result, plus the long hold-offs
    initial
    begin : result_sink
        int n;
        int holds_done;
        holds_done = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holds_done < hold_requests)
            begin
                n = HOLD_CYCLES;
                holds_done++;
            end
            else
                n = rcv_steady ? 0 : $urandom_range(0, 8);
            out_stall <= (n > 0);
            if (n > 0)
            begin
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // main sequence
    initial
    begin : stimulus
        int unsigned phase_total [PHASES];
        int unsigned tot;
        int          pct;
        phase_total = '{8, 64, 16383, 130, 0, 1, 8192, 300, 129, 0, 2, 40};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset total: take 1..3, free and re-take 2, double free,
        // zero, top entry never used, just past the total, all-ones number
        post_request(REQ_ALLOC, '0);
        post_request(REQ_ALLOC, NUM_W'(NUM_MAX));
        post_request(REQ_ALLOC, '0);
        post_request(REQ_FREE, NUM_W'(2));
        post_request(REQ_FREE, NUM_W'(2));
        post_request(REQ_ALLOC, '0);
        post_request(REQ_FREE, '0);
        post_request(REQ_FREE, NUM_W'(8192));
        post_request(REQ_FREE, NUM_W'(8193));
        post_request(REQ_FREE, NUM_W'(NUM_MAX));

        // zero total: allocate is full, any free is out of range
        drain_results();
        write_total('0);
        post_request(REQ_ALLOC, '0);
        post_request(REQ_FREE, NUM_W'(1));

        // total lowered under entries in use: entry 3 stays set and counted,
        // cannot be freed, and the free count saturates at zero
        drain_results();
        write_total(NUM_W'(2));
        post_request(REQ_ALLOC, '0);
        post_request(REQ_FREE, NUM_W'(3));
        post_request(REQ_FREE, NUM_W'(1));
        post_request(REQ_ALLOC, '0);

        // single entry
        drain_results();
        write_total(NUM_W'(1));
        post_request(REQ_ALLOC, '0);
        post_request(REQ_FREE, NUM_W'(1));
        post_request(REQ_ALLOC, '0);
        post_request(REQ_ALLOC, '0);
        post_request(REQ_FREE, NUM_W'(2));

        // largest register value, clamped to the array size; clean up the leftovers
        drain_results();
        write_total(NUM_W'(NUM_MAX));
        post_request(REQ_FREE, NUM_W'(3));
        post_request(REQ_FREE, NUM_W'(2));
        post_request(REQ_FREE, NUM_W'(1));
        post_request(REQ_ALLOC, '0);
        live_hint = 1;

        // random phases; zero slots in the table get a random total
        for (int p = 0; p < PHASES; p++)
        begin
            tot = (phase_total[p] == 0) ? $urandom_range(3, 600) : phase_total[p];
            pct = (p % 3 == 0) ? 70 : ((p % 3 == 1) ? 45 : 30);
            snd_steady = ($urandom_range(0, 3) == 0);
            rcv_steady = ($urandom_range(0, 3) == 0);
            drain_results();
            write_total(NUM_W'(tot));
            if (p == 2 || p == 7)
                hold_requests++;
            run_phase(tot, PHASE_ITEMS, pct);
        end

        drain_results();
        repeat (20) @(posedge clk);

        $display("%0d requests and %0d total writes driven, %0d results checked",
                 requests_sent, cfg_writes, checked);
        $display("granted %0d, released %0d, full %0d, out of range %0d, already free %0d",
                 n_granted, n_released, n_full, n_range, n_already);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hard stop if the block hangs
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
